[rtl/configurable_crc32_byte_engine_defines.svh]
// assertion macros for the configurable crc32 byte engine
// expects clk and rst_n in the scope of every use
`ifndef CONFIGURABLE_CRC32_BYTE_ENGINE_DEFINES_SVH
`define CONFIGURABLE_CRC32_BYTE_ENGINE_DEFINES_SVH

// condition holds in the same cycle
`define CRC32BE_ASSERT_NOW(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// condition holds in the next cycle
`define CRC32BE_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

[rtl/crc32be_pkg.sv]
// shared types, reset values and crc helper functions for the crc32 byte engine
// no dependencies
package crc32be_pkg;

  typedef enum logic [2:0] {
    CFG_POLYNOMIAL     = 3'd0,
    CFG_REFLECT_INPUT  = 3'd1,
    CFG_INITIAL_VALUE  = 3'd2,
    CFG_REFLECT_OUTPUT = 3'd3,
    CFG_FINAL_XOR      = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [31:0] polynomial;
    logic        reflect_input;
    logic [31:0] initial_value;
    logic        reflect_output;
    logic [31:0] final_xor;
  } cfg_t;

  typedef struct packed {
    logic s1_valid;
    logic s1_last;
    logic push;
  } dp_status_t;

  localparam logic [31:0] POLY_RESET  = 32'h04C1_1DB7;
  localparam logic [31:0] INIT_RESET  = 32'hFFFF_FFFF;
  localparam logic [31:0] FXOR_RESET  = 32'h0000_0000;

  function automatic logic [7:0] rev8(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i] = v[7-i];
    end
    return r;
  endfunction

  function automatic logic [31:0] rev32(input logic [31:0] v);
    logic [31:0] r;
    for (int i = 0; i < 32; i++) begin
      r[i] = v[31-i];
    end
    return r;
  endfunction

  // msb-first byte update; the reflected form is the same update on mirrored bits
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b,
                                           input logic [31:0] poly);
    logic [31:0] r;
    r = crc ^ {b, 24'h00_0000};
    for (int i = 0; i < 8; i++) begin
      r = r[31] ? ({r[30:0], 1'b0} ^ poly) : {r[30:0], 1'b0};
    end
    return r;
  endfunction

endpackage

[rtl/configurable_crc32_byte_engine.sv]
// configurable crc32 engine, one message byte per request
// uses crc32be_pkg, crc32be_cfg_regs, crc32be_datapath, crc32be_out_buf
//
// input stream: in_tdata carries one byte, in_tuser says the byte belongs to
// the message (low for an empty-message end marker or an idle request), and
// in_tlast ends the message. only a request with in_tlast high gives a result.
// output stream: out_tdata carries the finished 32-bit crc.
// config port: cfg_index picks polynomial(0), reflect_input(1),
// initial_value(2), reflect_output(3) or final_xor(4); cfg_ready is always
// high. any known write presets the running crc, dropping a partial message.
// throughput: one byte per cycle while no last byte waits for the result slot,
// set by the combinational byte update between the input register and the crc register.
// result path: a last byte passes the input register, then the result register drives out_tvalid.
// reset: settings return to crc-32/mpeg-2 and the crc register to all ones.
// stall: a held result keeps accepting non-last bytes; a last byte waits in
// the input register with in_tready low until the result slot frees.
module configurable_crc32_byte_engine (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] byte_valid
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] crc_value
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  `include "configurable_crc32_byte_engine_defines.svh"

  crc32be_pkg::cfg_t       cfg;
  crc32be_pkg::dp_status_t status;
  logic                    preset;
  logic                    out_free;
  logic [31:0]             result;

  assign cfg_ready = 1'b1;

  crc32be_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg),
    .preset    (preset)
  );

  crc32be_datapath u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg),
    .preset        (preset),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_byte       (in_tdata),
    .in_byte_valid (in_tuser),
    .in_last       (in_tlast),
    .out_free      (out_free),
    .result        (result),
    .status        (status)
  );

  crc32be_out_buf u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (status.push),
    .push_data  (result),
    .free       (out_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // a new result never lands on one still waiting
  `CRC32BE_ASSERT_NOW(a_no_overwrite, status.push && out_tvalid, out_tready, "result overwritten")
  `CRC32BE_ASSERT_NEXT(a_push_shows, status.push, out_tvalid, "pushed result not presented")
  `CRC32BE_ASSERT_NOW(a_last_waits,
    status.s1_valid && status.s1_last && out_tvalid && !out_tready,
    !in_tready && !status.push, "last byte advanced into a full result slot")

endmodule

[rtl/crc32be_cfg_regs.sv]
// configuration register file of the crc32 byte engine
// depends on crc32be_pkg
module crc32be_cfg_regs (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_valid,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  output crc32be_pkg::cfg_t   cfg,
  output logic                preset
);

  crc32be_pkg::cfg_t cfg_r, cfg_nxt;
  logic              preset_r, preset_nxt;

  always_comb begin
    cfg_nxt    = cfg_r;
    preset_nxt = 1'b0;
    if (cfg_valid) begin
      preset_nxt = 1'b1;
      unique case (crc32be_pkg::cfg_idx_t'(cfg_index))
        crc32be_pkg::CFG_POLYNOMIAL:     cfg_nxt.polynomial     = cfg_data;
        crc32be_pkg::CFG_REFLECT_INPUT:  cfg_nxt.reflect_input  = cfg_data[0];
        crc32be_pkg::CFG_INITIAL_VALUE:  cfg_nxt.initial_value  = cfg_data;
        crc32be_pkg::CFG_REFLECT_OUTPUT: cfg_nxt.reflect_output = cfg_data[0];
        crc32be_pkg::CFG_FINAL_XOR:      cfg_nxt.final_xor      = cfg_data;
        // unknown index leaves everything untouched
        default:                         preset_nxt = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.polynomial     <= crc32be_pkg::POLY_RESET;
      cfg_r.reflect_input  <= 1'b0;
      cfg_r.initial_value  <= crc32be_pkg::INIT_RESET;
      cfg_r.reflect_output <= 1'b0;
      cfg_r.final_xor      <= crc32be_pkg::FXOR_RESET;
      preset_r             <= 1'b0;
    end else begin
      cfg_r    <= cfg_nxt;
      preset_r <= preset_nxt;
    end
  end

  assign cfg    = cfg_r;
  assign preset = preset_r;

endmodule

[rtl/crc32be_datapath.sv]
// input register, running crc register and finishing logic
// depends on crc32be_pkg
module crc32be_datapath (
  input  logic                    clk,
  input  logic                    rst_n,
  input  crc32be_pkg::cfg_t       cfg,
  input  logic                    preset,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  input  logic [7:0]              in_byte,
  input  logic                    in_byte_valid,
  input  logic                    in_last,
  input  logic                    out_free,
  output logic [31:0]             result,
  output crc32be_pkg::dp_status_t status
);

  logic        s1_valid_r, s1_valid_nxt;
  logic [7:0]  s1_byte_r;
  logic        s1_bvalid_r;
  logic        s1_last_r;
  logic [31:0] crc_r, crc_nxt;
  logic        s1_adv;
  logic        in_acc;
  logic [7:0]  feed_byte;
  logic [31:0] crc_upd;
  logic [31:0] crc_fin;

  // register kept msb-first; a reflected run feeds mirrored bytes
  assign feed_byte = cfg.reflect_input ? crc32be_pkg::rev8(s1_byte_r) : s1_byte_r;
  assign crc_upd   = s1_bvalid_r ? crc32be_pkg::crc_byte(crc_r, feed_byte, cfg.polynomial)
                                 : crc_r;
  assign crc_fin   = cfg.reflect_output ? crc32be_pkg::rev32(crc_upd) : crc_upd;
  assign result    = crc_fin ^ cfg.final_xor;

  // an item without tlast never needs the output slot
  assign s1_adv    = s1_valid_r && (!s1_last_r || out_free);
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
    crc_nxt = crc_r;
    if (preset) begin
      crc_nxt = cfg.initial_value;
    end else if (s1_adv) begin
      crc_nxt = s1_last_r ? cfg.initial_value : crc_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      crc_r      <= crc32be_pkg::INIT_RESET;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      crc_r      <= crc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_byte_r   <= in_byte;
      s1_bvalid_r <= in_byte_valid;
      s1_last_r   <= in_last;
    end
  end

  assign status = '{s1_valid: s1_valid_r, s1_last: s1_last_r, push: s1_adv && s1_last_r};

endmodule

[rtl/crc32be_out_buf.sv]
// result register on the output stream
// no dependencies
module crc32be_out_buf (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  logic [31:0] push_data,
  output logic        free,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata
);

  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_data_r;

  assign free = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (push) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_data_r <= push_data;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
